### hdl/sls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sls_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_UNKNOWNS_DEF = 5;
	localparam int FRAC_BITS_DEF    = 16;

	// Configuration port shape and register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 31;
	localparam logic [CFG_INDEX_W-1:0] REG_SYSTEM_SIZE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_PIVOT   = 2'd1;

	// Opcodes and result status codes.
	localparam logic OP_LOAD     = 1'b0;
	localparam logic OP_SOLVE    = 1'b1;
	localparam logic ST_OK       = 1'b0;
	localparam logic ST_SINGULAR = 1'b1;

	typedef logic signed [31:0] q_t;
	typedef logic signed [63:0] wide_t;

	// Magnitude of a Q value, one bit wider so that the most negative value fits.
	function automatic logic [32:0] mag33(input q_t v);
		logic [32:0] e;
		e = {v[31], v};
		return v[31] ? (~e + 33'd1) : e;
	endfunction

	// Clamp a 64-bit value into the 32-bit signed range.
	function automatic q_t sat32(input wide_t v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

`default_nettype wire

### hdl/sls_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sls_cmd_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [2:0]  row;
	logic [2:0]  column;
	logic signed [31:0] value;

	modport source (output valid, opcode, row, column, value, input ready);
	modport sink (input valid, opcode, row, column, value, output ready);
endinterface

`default_nettype wire

### hdl/sls_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sls_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic signed [31:0] solution;
	logic        status;
	logic        last;

	modport source (output valid, index, solution, status, last, input ready);
	modport sink (input valid, index, solution, status, last, output ready);
endinterface

`default_nettype wire

### hdl/small_linear_system_solver.sv
`timescale 1ns / 1ps
`default_nettype none
// A load beat gives no result. A solve copies the stored matrix into the working
// matrix, then searches each pivot column, swaps rows entry by entry, divides (one
// quotient bit a cycle in the shared divider) and multiply-subtracts through the
// one work-matrix port, then delivers the result beats.
// No new beat is taken until the last result is delivered.
// Reset (arst_n low) returns the sequencer to idle, system_size to 5 and min_pivot to 0.
module small_linear_system_solver #(
	parameter int MAX_UNKNOWNS = sls_pkg::MAX_UNKNOWNS_DEF,
	parameter int FRAC_BITS    = sls_pkg::FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [sls_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [sls_pkg::CFG_DATA_W-1:0]  cfg_data,
	sls_cmd_if.sink                             cmd,
	sls_res_if.source                           res
);
	import sls_pkg::*;

	localparam int C    = MAX_UNKNOWNS + 1;
	localparam int RC   = MAX_UNKNOWNS * C;
	localparam int AW   = $clog2(RC);
	localparam int IW   = $clog2(MAX_UNKNOWNS + 2);
	localparam int DIVW = 64;
	localparam int DCW  = $clog2(DIVW + 1);
	localparam logic [IW-1:0] RHS = IW'(MAX_UNKNOWNS);

	// Sequencer states.
	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_COPY    = 5'd1;
	localparam logic [4:0] S_PV_RD   = 5'd2;
	localparam logic [4:0] S_PV_EX   = 5'd3;
	localparam logic [4:0] S_DECIDE  = 5'd4;
	localparam logic [4:0] S_SW_A    = 5'd5;
	localparam logic [4:0] S_SW_B    = 5'd6;
	localparam logic [4:0] S_SW_C    = 5'd7;
	localparam logic [4:0] S_SW_D    = 5'd8;
	localparam logic [4:0] S_PK_RD   = 5'd9;
	localparam logic [4:0] S_PK_EX   = 5'd10;
	localparam logic [4:0] S_EM_RD   = 5'd11;
	localparam logic [4:0] S_EM_EX   = 5'd12;
	localparam logic [4:0] S_DIV     = 5'd13;
	localparam logic [4:0] S_EL_RA   = 5'd14;
	localparam logic [4:0] S_EL_RB   = 5'd15;
	localparam logic [4:0] S_EL_MUL  = 5'd16;
	localparam logic [4:0] S_EL_WR   = 5'd17;
	localparam logic [4:0] S_BS_INIT = 5'd18;
	localparam logic [4:0] S_BS_RA   = 5'd19;
	localparam logic [4:0] S_BS_RB   = 5'd20;
	localparam logic [4:0] S_BS_MUL  = 5'd21;
	localparam logic [4:0] S_BS_ACC  = 5'd22;
	localparam logic [4:0] S_BS_RHS  = 5'd23;
	localparam logic [4:0] S_BS_RD   = 5'd24;
	localparam logic [4:0] S_BS_DV   = 5'd25;
	localparam logic [4:0] S_BS_WR   = 5'd26;
	localparam logic [4:0] S_OT_RD   = 5'd27;
	localparam logic [4:0] S_OT_EX   = 5'd28;
	localparam logic [4:0] S_OT_WAIT = 5'd29;

	function automatic logic [AW-1:0] ea(input logic [IW-1:0] r, input logic [IW-1:0] c);
		return AW'(r) * AW'(C) + AW'(c);
	endfunction

	logic [4:0]    state_q, ret_q;
	logic [2:0]    size_q;
	logic [30:0]   min_pivot_q;
	logic [IW-1:0] n_q, k_q, i_q, j_q, r_q;
	logic [AW-1:0] e_q, cp_a_q;
	logic          cp_v_q;
	logic [32:0]   best_q;
	q_t            dkk_q, opa_q, aij_q, quot_q;
	wide_t         prod_q, acc_q;

	// Shared divider registers.
	logic [63:0]   dv_q;
	logic [31:0]   dv_rem_q, dv_den_q;
	logic          dv_neg_q, dv_zero_q;
	logic [DCW-1:0] dv_cnt_q;

	// Result register.
	logic          out_v_q, out_st_q, out_last_q;
	logic [2:0]    out_idx_q;
	q_t            out_sol_q;

	// Stored matrix and working matrix.
	q_t            sm [RC];
	q_t            wm [RC];
	q_t            sm_rdata_q, wm_rdata_q;
	logic [AW-1:0] wm_raddr, wm_waddr;
	logic          wm_we;
	q_t            wm_wdata;

	logic          cmd_fire, res_fire, load_ok;
	logic [32:0]   rd_mag;
	logic [32:0]   dkk_mag;
	logic [32:0]   dv_t;
	logic          dv_ge;
	logic [63:0]   num_mag;
	q_t            div_result;
	q_t            el_value;

	assign cmd.ready    = (state_q == S_IDLE);
	assign cmd_fire     = cmd.valid && cmd.ready;
	assign res_fire     = out_v_q && res.ready;
	assign res.valid    = out_v_q;
	assign res.index    = out_idx_q;
	assign res.solution = out_sol_q;
	assign res.status   = out_st_q;
	assign res.last     = out_last_q;
	assign load_ok      = (int'(cmd.row) < MAX_UNKNOWNS) && (int'(cmd.column) <= MAX_UNKNOWNS);
	assign rd_mag       = mag33(wm_rdata_q);
	assign dkk_mag      = mag33(dkk_q);

	// Divider step: one quotient bit per cycle.
	assign dv_t  = {dv_rem_q, dv_q[63]};
	assign dv_ge = dv_t >= {1'b0, dv_den_q};

	// Divider numerator magnitude for the start cycles.
	always_comb begin
		num_mag = '0;
		if (state_q == S_EM_EX) begin
			num_mag = 64'(mag33(wm_rdata_q)) << FRAC_BITS;
		end else begin
			num_mag = 64'(mag33(opa_q)) << FRAC_BITS;
		end
	end

	// Final quotient with sign and saturation.
	always_comb begin
		if (dv_zero_q) begin
			div_result = '0;
		end else if (dv_neg_q) begin
			div_result = (dv_q > 64'h80000000) ? 32'sh80000000 : q_t'(~dv_q[31:0] + 32'd1);
		end else begin
			div_result = (dv_q > 64'h7fffffff) ? 32'sh7fffffff : q_t'(dv_q[31:0]);
		end
	end

	assign el_value = sat32(wide_t'(aij_q) - (prod_q >>> FRAC_BITS));

	// Working-matrix port control.
	always_comb begin
		wm_raddr = '0;
		wm_we    = 1'b0;
		wm_waddr = cp_a_q;
		wm_wdata = sm_rdata_q;
		case (state_q)
			S_PV_RD:  wm_raddr = ea(i_q, k_q);
			S_SW_A:   wm_raddr = ea(k_q, j_q);
			S_SW_B:   wm_raddr = ea(r_q, j_q);
			S_PK_RD:  wm_raddr = ea(k_q, k_q);
			S_EM_RD:  wm_raddr = ea(i_q, k_q);
			S_EL_RA:  wm_raddr = ea(k_q, j_q);
			S_EL_RB:  wm_raddr = ea(i_q, j_q);
			S_BS_RA:  wm_raddr = ea(i_q, j_q);
			S_BS_RB:  wm_raddr = ea(j_q, RHS);
			S_BS_RHS: wm_raddr = ea(i_q, RHS);
			S_BS_RD:  wm_raddr = ea(i_q, i_q);
			S_OT_RD:  wm_raddr = ea(i_q, RHS);
			default:  wm_raddr = '0;
		endcase
		if (cp_v_q) begin
			wm_we = 1'b1;
		end else begin
			case (state_q)
				S_SW_C: begin
					wm_we    = 1'b1;
					wm_waddr = ea(k_q, j_q);
					wm_wdata = wm_rdata_q;
				end
				S_SW_D: begin
					wm_we    = 1'b1;
					wm_waddr = ea(r_q, j_q);
					wm_wdata = opa_q;
				end
				S_EL_WR: begin
					wm_we    = 1'b1;
					wm_waddr = ea(i_q, j_q);
					wm_wdata = el_value;
				end
				S_BS_WR: begin
					wm_we    = 1'b1;
					wm_waddr = ea(i_q, RHS);
					wm_wdata = quot_q;
				end
				default: wm_we = 1'b0;
			endcase
		end
	end

	// Memories: stored matrix written by load beats, working matrix by the sequencer.
	always_ff @(posedge clk) begin
		if (cmd_fire && cmd.opcode == OP_LOAD && load_ok) begin
			sm[ea(IW'(cmd.row), IW'(cmd.column))] <= cmd.value;
		end
		sm_rdata_q <= sm[e_q];
		if (wm_we) begin
			wm[wm_waddr] <= wm_wdata;
		end
		wm_rdata_q <= wm[wm_raddr];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= 3'd5;
			min_pivot_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_SYSTEM_SIZE) begin
				size_q <= cfg_data[2:0];
			end else if (cfg_index == REG_MIN_PIVOT) begin
				min_pivot_q <= cfg_data;
			end
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
			cp_v_q  <= 1'b0;
		end else begin
			cp_v_q <= (state_q == S_COPY);
			cp_a_q <= e_q;
			case (state_q)
				S_IDLE: begin
					if (cmd_fire && cmd.opcode == OP_SOLVE) begin
						n_q <= IW'(size_q);
						if (size_q == 3'd0 || int'(size_q) > MAX_UNKNOWNS) begin
							out_v_q    <= 1'b1;
							out_idx_q  <= '0;
							out_sol_q  <= '0;
							out_st_q   <= ST_SINGULAR;
							out_last_q <= 1'b1;
							state_q    <= S_OT_WAIT;
						end else begin
							e_q     <= '0;
							state_q <= S_COPY;
						end
					end
				end
				S_COPY: begin
					if (e_q == AW'(RC - 1)) begin
						k_q     <= '0;
						i_q     <= '0;
						state_q <= S_PV_RD;
					end else begin
						e_q <= e_q + AW'(1);
					end
				end
				S_PV_RD: state_q <= S_PV_EX;
				S_PV_EX: begin
					if (i_q == k_q || rd_mag > best_q) begin
						best_q <= rd_mag;
						r_q    <= i_q;
					end
					if (i_q == n_q - IW'(1)) begin
						state_q <= S_DECIDE;
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= S_PV_RD;
					end
				end
				S_DECIDE: begin
					if (best_q <= {2'b00, min_pivot_q}) begin
						out_v_q    <= 1'b1;
						out_idx_q  <= '0;
						out_sol_q  <= '0;
						out_st_q   <= ST_SINGULAR;
						out_last_q <= 1'b1;
						state_q    <= S_OT_WAIT;
					end else if (r_q != k_q) begin
						j_q     <= '0;
						state_q <= S_SW_A;
					end else begin
						state_q <= S_PK_RD;
					end
				end
				S_SW_A: state_q <= S_SW_B;
				S_SW_B: begin
					opa_q   <= wm_rdata_q;
					state_q <= S_SW_C;
				end
				S_SW_C: state_q <= S_SW_D;
				S_SW_D: begin
					if (j_q == RHS) begin
						state_q <= S_PK_RD;
					end else begin
						j_q     <= j_q + IW'(1);
						state_q <= S_SW_A;
					end
				end
				S_PK_RD: state_q <= S_PK_EX;
				S_PK_EX: begin
					dkk_q <= wm_rdata_q;
					if (k_q == n_q - IW'(1)) begin
						i_q     <= n_q - IW'(1);
						state_q <= S_BS_INIT;
					end else begin
						i_q     <= k_q + IW'(1);
						state_q <= S_EM_RD;
					end
				end
				S_EM_RD: state_q <= S_EM_EX;
				S_EM_EX: begin
					// Multiplier for this row: a[i][k] / pivot.
					dv_q      <= num_mag;
					dv_rem_q  <= '0;
					dv_den_q  <= dkk_mag[31:0];
					dv_neg_q  <= wm_rdata_q[31] ^ dkk_q[31];
					dv_zero_q <= (dkk_q == '0);
					dv_cnt_q  <= '0;
					j_q       <= k_q;
					ret_q     <= S_EL_RA;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					if (dv_cnt_q == DCW'(DIVW)) begin
						quot_q  <= div_result;
						state_q <= ret_q;
					end else begin
						dv_rem_q <= dv_ge ? 32'(dv_t - {1'b0, dv_den_q}) : dv_t[31:0];
						dv_q     <= {dv_q[62:0], dv_ge};
						dv_cnt_q <= dv_cnt_q + DCW'(1);
					end
				end
				S_EL_RA: state_q <= S_EL_RB;
				S_EL_RB: begin
					opa_q   <= wm_rdata_q;
					state_q <= S_EL_MUL;
				end
				S_EL_MUL: begin
					aij_q   <= wm_rdata_q;
					prod_q  <= quot_q * opa_q;
					state_q <= S_EL_WR;
				end
				S_EL_WR: begin
					if (j_q == RHS) begin
						if (i_q == n_q - IW'(1)) begin
							k_q     <= k_q + IW'(1);
							i_q     <= k_q + IW'(1);
							state_q <= S_PV_RD;
						end else begin
							i_q     <= i_q + IW'(1);
							state_q <= S_EM_RD;
						end
					end else begin
						j_q     <= (j_q == n_q - IW'(1)) ? RHS : j_q + IW'(1);
						state_q <= S_EL_RA;
					end
				end
				S_BS_INIT: begin
					acc_q   <= '0;
					j_q     <= i_q + IW'(1);
					state_q <= S_BS_RA;
				end
				S_BS_RA: state_q <= (j_q == n_q) ? S_BS_RHS : S_BS_RB;
				S_BS_RB: begin
					opa_q   <= wm_rdata_q;
					state_q <= S_BS_MUL;
				end
				S_BS_MUL: begin
					prod_q  <= opa_q * wm_rdata_q;
					state_q <= S_BS_ACC;
				end
				S_BS_ACC: begin
					acc_q   <= acc_q + (prod_q >>> FRAC_BITS);
					j_q     <= j_q + IW'(1);
					state_q <= S_BS_RA;
				end
				S_BS_RHS: state_q <= S_BS_RD;
				S_BS_RD: begin
					opa_q   <= sat32(wide_t'(wm_rdata_q) - acc_q);
					state_q <= S_BS_DV;
				end
				S_BS_DV: begin
					// Unknown i: (rhs - sum) / a[i][i].
					dv_q      <= num_mag;
					dv_rem_q  <= '0;
					dv_den_q  <= rd_mag[31:0];
					dv_neg_q  <= opa_q[31] ^ wm_rdata_q[31];
					dv_zero_q <= (wm_rdata_q == '0) || (opa_q == '0);
					dv_cnt_q  <= '0;
					ret_q     <= S_BS_WR;
					state_q   <= S_DIV;
				end
				S_BS_WR: begin
					if (i_q == '0) begin
						state_q <= S_OT_RD;
					end else begin
						i_q     <= i_q - IW'(1);
						state_q <= S_BS_INIT;
					end
				end
				S_OT_RD: state_q <= S_OT_EX;
				S_OT_EX: begin
					out_v_q    <= 1'b1;
					out_idx_q  <= 3'(i_q);
					out_sol_q  <= wm_rdata_q;
					out_st_q   <= ST_OK;
					out_last_q <= (i_q == n_q - IW'(1));
					state_q    <= S_OT_WAIT;
				end
				S_OT_WAIT: begin
					if (res_fire) begin
						out_v_q <= 1'b0;
						if (out_last_q) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + IW'(1);
							state_q <= S_OT_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### tb/tb_small_linear_system_solver.sv
`timescale 1ns / 1ps

module tb_small_linear_system_solver;
	import sls_pkg::*;

	localparam int N_MAX     = 5;
	localparam int FRAC      = 16;
	localparam int RHS_COL   = N_MAX;
	localparam int IDLE_PCT  = 14;
	localparam int STALL_LIM = 50000;

	typedef struct {
		logic [2:0] index;
		q_t         solution;
		logic       status;
		logic       last;
	} solution_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	sls_cmd_if cmd_ch();
	sls_res_if res_ch();

	small_linear_system_solver i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cmd(cmd_ch), .res(res_ch)
	);

	// Mirror of the block's stored matrix and registers.
	q_t         coef [0:N_MAX-1][0:N_MAX];
	logic [2:0] size_reg;
	logic [30:0] pivot_floor;

	solution_t solutions_due[$];
	int  mismatches;
	int  beats_sent;
	bit  steady;
	int  quiet_cycles;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Fixed-point helpers for the elimination predictor.
	function automatic q_t clamp_q(input wide_t v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return q_t'(v[31:0]);
	endfunction

	function automatic wide_t fixed_mul(input q_t a, input q_t b);
		wide_t p;
		p = wide_t'(a) * wide_t'(b);
		return p >>> FRAC;
	endfunction

	function automatic q_t fixed_div(input q_t n, input q_t d);
		wide_t num;
		if (d == 0) return 32'sd0;
		num = wide_t'(n) <<< FRAC;
		return clamp_q(num / wide_t'(d));
	endfunction

	function automatic wide_t magnitude(input q_t v);
		return (v < 0) ? -wide_t'(v) : wide_t'(v);
	endfunction

	// Gaussian elimination with partial pivoting on a copy of the stored matrix.
	function automatic void predict_solve();
		q_t w [0:N_MAX-1][0:N_MAX];
		q_t x [0:N_MAX-1];
		q_t tmp, m;
		wide_t best, s;
		int n, r;
		solution_t sol;
		n = size_reg;
		w = coef;
		for (int i = 0; i < N_MAX; i++) x[i] = 0;
		sol = '{3'd0, 32'sd0, ST_SINGULAR, 1'b1};
		if (n < 1 || n > N_MAX) begin
			solutions_due.push_back(sol);
			return;
		end
		for (int k = 0; k < n; k++) begin
			best = magnitude(w[k][k]);
			r = k;
			for (int i = k + 1; i < n; i++) begin
				if (magnitude(w[i][k]) > best) begin
					best = magnitude(w[i][k]);
					r = i;
				end
			end
			if (r != k) begin
				for (int j = 0; j <= N_MAX; j++) begin
					tmp = w[k][j];
					w[k][j] = w[r][j];
					w[r][j] = tmp;
				end
			end
			if (best <= wide_t'({1'b0, pivot_floor})) begin
				solutions_due.push_back(sol);
				return;
			end
			for (int i = k + 1; i < n; i++) begin
				m = fixed_div(w[i][k], w[k][k]);
				for (int j = k; j < n; j++)
					w[i][j] = clamp_q(wide_t'(w[i][j]) - fixed_mul(m, w[k][j]));
				w[i][RHS_COL] = clamp_q(wide_t'(w[i][RHS_COL]) - fixed_mul(m, w[k][RHS_COL]));
			end
		end
		for (int i = n - 1; i >= 0; i--) begin
			s = 0;
			for (int j = i + 1; j < n; j++) s += fixed_mul(w[i][j], x[j]);
			x[i] = fixed_div(clamp_q(wide_t'(w[i][RHS_COL]) - s), w[i][i]);
		end
		for (int i = 0; i < n; i++) begin
			sol = '{i[2:0], x[i], ST_OK, (i == n - 1)};
			solutions_due.push_back(sol);
		end
	endfunction

	// Send one command beat and update the mirror when it is taken.
	task automatic send_cmd(input logic op, input logic [2:0] row, input logic [2:0] col,
			input q_t val);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid  <= 1'b1;
		cmd_ch.opcode <= op;
		cmd_ch.row    <= row;
		cmd_ch.column <= col;
		cmd_ch.value  <= val;
		do @(posedge clk); while (!cmd_ch.ready);
		beats_sent++;
		if (op == OP_SOLVE) begin
			predict_solve();
		end else if (row < N_MAX && col <= N_MAX) begin
			coef[row][col] = val;
		end
	endtask

	// Hold off until every solution has arrived and the block has gone quiet.
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (solutions_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [30:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_SYSTEM_SIZE) size_reg = data[2:0];
		else if (idx == REG_MIN_PIVOT) pivot_floor = data;
	endtask

	// Random Q value with a random magnitude scale.
	function automatic q_t rand_q();
		return $signed($urandom) >>> $urandom_range(0, 31);
	endfunction

	// A well-conditioned entry: strong on the diagonal, small elsewhere.
	function automatic q_t dominant_q(input int r, input int c);
		q_t v;
		v = $signed($urandom) >>> $urandom_range(14, 31);
		if (r == c) v = (v < 0) ? v - 32'sh00080000 : v + 32'sh00080000;
		return v;
	endfunction

	// Fill the whole matrix so that no solve reads an unwritten entry.
	task automatic test_full_load();
		for (int r = 0; r < N_MAX; r++)
			for (int c = 0; c <= N_MAX; c++)
				send_cmd(OP_LOAD, r[2:0], c[2:0], dominant_q(r, c));
		send_cmd(OP_LOAD, 3'd0, 3'd5, 32'sh7fffffff);
		send_cmd(OP_LOAD, 3'd1, 3'd5, 32'sh80000000);
		// Loads outside the matrix must be ignored.
		send_cmd(OP_LOAD, 3'd7, 3'd0, 32'sh12345678);
		send_cmd(OP_LOAD, 3'd0, 3'd7, 32'sh12345678);
		send_cmd(OP_SOLVE, 3'd0, 3'd0, 32'sd0);
	endtask

	// Every size, including the illegal ones, and the pivot threshold extremes.
	task automatic test_sizes_and_threshold();
		for (int s = 0; s < 8; s++) begin
			drain();
			write_reg(REG_SYSTEM_SIZE, s[30:0]);
			send_cmd(OP_SOLVE, 3'd0, 3'd0, 32'sd0);
		end
		drain();
		write_reg(REG_SYSTEM_SIZE, 31'd5);
		write_reg(REG_MIN_PIVOT, 31'h7fffffff);
		send_cmd(OP_SOLVE, 3'd0, 3'd0, 32'sd0);
		drain();
		write_reg(REG_MIN_PIVOT, 31'd0);
		// Equal magnitudes in the first column: the earliest row must win.
		send_cmd(OP_LOAD, 3'd0, 3'd0, 32'sh00010000);
		send_cmd(OP_LOAD, 3'd1, 3'd0, -32'sh00040000);
		send_cmd(OP_LOAD, 3'd2, 3'd0, 32'sh00040000);
		send_cmd(OP_SOLVE, 3'd0, 3'd0, 32'sd0);
		// A zero column is singular even with a zero threshold.
		for (int r = 0; r < N_MAX; r++) send_cmd(OP_LOAD, r[2:0], 3'd2, 32'sd0);
		send_cmd(OP_SOLVE, 3'd0, 3'd0, 32'sd0);
	endtask

	// Random load-then-solve sequences with occasional noise and register changes.
	task automatic test_random_systems();
		int n;
		bit tame;
		logic [2:0] row, col;
		steady = 1'b1;
		while (beats_sent < 280) begin
			if (beats_sent > 130) steady = 1'b0;
			if ($urandom_range(99) < 20) begin
				drain();
				write_reg(REG_SYSTEM_SIZE, ($urandom_range(99) < 90) ?
					31'($urandom_range(1, 5)) : 31'($urandom_range(0, 7)));
				write_reg(REG_MIN_PIVOT, ($urandom_range(99) < 70) ? 31'd0 :
					31'($urandom) >> $urandom_range(0, 30));
			end
			n = (size_reg >= 1 && size_reg <= N_MAX) ? size_reg : N_MAX;
			if ($urandom_range(99) < 80) begin
				tame = ($urandom_range(99) < 70);
				for (int r = 0; r < n; r++)
					for (int c = 0; c <= N_MAX; c++)
						if ((c < n || c == RHS_COL) && $urandom_range(99) < 60)
							send_cmd(OP_LOAD, r[2:0], c[2:0],
								tame ? dominant_q(r, c) : rand_q());
				send_cmd(OP_SOLVE, 3'($urandom), 3'($urandom), $signed($urandom));
			end else begin
				repeat ($urandom_range(1, 6)) begin
					row = 3'($urandom);
					col = 3'($urandom);
					send_cmd(OP_LOAD, row, col, $signed($urandom));
				end
			end
		end
	endtask

	// Result checker and receiver stalls.
	always @(posedge clk) begin
		solution_t exp_sol;
		if (res_ch.valid && res_ch.ready) begin
			if (solutions_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result beat: index %0d solution %0d",
						res_ch.index, res_ch.solution);
			end else begin
				exp_sol = solutions_due.pop_front();
				if (res_ch.index !== exp_sol.index || res_ch.solution !== exp_sol.solution ||
						res_ch.status !== exp_sol.status || res_ch.last !== exp_sol.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"Mismatch: expected idx %0d sol %0d st %0d last %0d,",
							" got idx %0d sol %0d st %0d last %0d"},
							exp_sol.index, exp_sol.solution, exp_sol.status, exp_sol.last,
							res_ch.index, res_ch.solution, res_ch.status, res_ch.last);
				end
			end
		end
		res_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIM) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		cmd_ch.valid  = 1'b0;
		cmd_ch.opcode = OP_LOAD;
		cmd_ch.row    = '0;
		cmd_ch.column = '0;
		cmd_ch.value  = '0;
		res_ch.ready  = 1'b0;
		mismatches    = 0;
		beats_sent    = 0;
		steady        = 1'b0;
		quiet_cycles  = 0;
		size_reg      = 3'd5;
		pivot_floor   = '0;
		for (int r = 0; r < N_MAX; r++)
			for (int c = 0; c <= N_MAX; c++) coef[r][c] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_full_load();
		test_sizes_and_threshold();
		test_random_systems();
		drain();
		if (mismatches == 0 && solutions_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
